// ----- rtl/core/slot_table_with_free_stack_macros.svh -----
// ----------------------------------------------------------------------------
// Slot table assertion macros
// Shorthand for clocked implication checks with active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef SLOT_TABLE_WITH_FREE_STACK_MACROS_SVH
`define SLOT_TABLE_WITH_FREE_STACK_MACROS_SVH

// same-cycle implication
`define STFS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STFS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/stfs_pkg.sv -----
// ----------------------------------------------------------------------------
// Slot table package
// Command, status and state codes shared by the slot table design.
// ----------------------------------------------------------------------------
package stfs_pkg;

  localparam int SLOT_W  = 10;
  localparam int CMD_W   = 3;
  localparam int VALUE_W = 32;
  localparam int STS_W   = 2;
  localparam int COUNT_W = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH     = 3'd0,
    CMD_FREE     = 3'd1,
    CMD_REMOVE   = 3'd2,
    CMD_POP      = 3'd3,
    CMD_READ     = 3'd4,
    CMD_READ_TOP = 3'd5
  } cmd_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_RANGE     = 2'd2,
    STS_FREE_FULL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDATA,
    S_SLOT,
    S_SHIFT
  } fsm_t;

endpackage

// ----- rtl/core/slot_table_with_free_stack.sv -----
// ----------------------------------------------------------------------------
// Slot table with free stack
// Element table with a LIFO stack of freed slots; push reuses freed slots
// first, remove shifts later elements down through the element memory.
// ----------------------------------------------------------------------------
//  channel | ports                                         | dir
//  --------+-----------------------------------------------+----
//  in      | in_valid/in_ready, cmd, slot_index, write_value | in
//  out     | out_valid/out_ready, result_index, read_value,  | out
//          | status, count_now                               |
//
//  Pop, free, appending push, removing the last element, errors: result from
//  S_EXEC. Read, read top, push into a freed slot: memory read in S_EXEC,
//  result from S_RDATA or S_SLOT. Remove of an inner element: S_EXEC, then
//  S_SHIFT moves one element per cycle through element memory read/write ports.
//  No clearing pass after reset; both memories are undefined until written.
//  A command waits in its execute step while the previous result is unclaimed.
`include "slot_table_with_free_stack_macros.svh"

module slot_table_with_free_stack
  import stfs_pkg::*;
#(
  parameter int TABLE_DEPTH   = 1024,
  parameter int ELEMENT_WIDTH = 32,
  parameter int FREE_DEPTH    = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [SLOT_W-1:0]    in_slot_index,
  input  logic [VALUE_W-1:0]   in_write_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SLOT_W-1:0]    out_result_index,
  output logic [VALUE_W-1:0]   out_read_value,
  output logic [STS_W-1:0]     out_status,
  output logic [COUNT_W-1:0]   out_count_now
);

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int LW  = $clog2(TABLE_DEPTH + 1);
  localparam int FW  = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
  localparam int FCW = $clog2(FREE_DEPTH + 1);
  localparam int CW  = LW + SLOT_W;

  logic [ELEMENT_WIDTH-1:0] elem_mem [TABLE_DEPTH];
  logic [SLOT_W-1:0]        fs_mem   [FREE_DEPTH];

  fsm_t                 state_r, state_nxt;
  logic [CMD_W-1:0]     cmd_r;
  logic [SLOT_W-1:0]    idx_r;
  logic [VALUE_W-1:0]   wval_r;
  logic [LW-1:0]        len_r, len_nxt;
  logic [FCW-1:0]       fc_r, fc_nxt;
  logic [LW-1:0]        sh_rd_r, sh_rd_nxt;
  logic [AW-1:0]        wa_r, wa_nxt;
  logic                 pend_r, pend_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0]    out_idx_r;
  logic [VALUE_W-1:0]   out_val_r;
  logic [STS_W-1:0]     out_sts_r;
  logic [COUNT_W-1:0]   out_cnt_r;

  logic                     elem_we, elem_re;
  logic [AW-1:0]            elem_wa, elem_ra;
  logic [ELEMENT_WIDTH-1:0] elem_wd, elem_rd_r;
  logic                     fs_we, fs_re;
  logic [FW-1:0]            fs_wa, fs_ra;
  logic [SLOT_W-1:0]        fs_wd, fs_rd_r;

  logic                 emit;
  logic [SLOT_W-1:0]    res_idx;
  logic [VALUE_W-1:0]   res_val;
  status_t              res_sts;

  logic in_fire, out_free, idx_ok, idx_tail, len_zero, fs_empty, fs_full, tbl_full;
  logic sh_more, slot_ok;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign idx_ok   = CW'(idx_r) < CW'(len_r);
  assign idx_tail = (CW'(idx_r) + CW'(1)) < CW'(len_r);
  assign len_zero = (len_r == '0);
  assign tbl_full = (len_r == LW'(TABLE_DEPTH));
  assign fs_empty = (fc_r == '0);
  assign fs_full  = (fc_r == FCW'(FREE_DEPTH));
  assign sh_more  = sh_rd_r < len_r;
  assign slot_ok  = CW'(fs_rd_r) < CW'(TABLE_DEPTH);

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_index = out_idx_r;
  assign out_read_value   = out_val_r;
  assign out_status       = out_sts_r;
  assign out_count_now    = out_cnt_r;

  always_ff @(posedge clk) begin
    if (elem_we) elem_mem[elem_wa] <= elem_wd;
    if (elem_re) elem_rd_r <= elem_mem[elem_ra];
  end

  always_ff @(posedge clk) begin
    if (fs_we) fs_mem[fs_wa] <= fs_wd;
    if (fs_re) fs_rd_r <= fs_mem[fs_ra];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          state_nxt = S_IDLE;
          case (cmd_t'(cmd_r))
            CMD_PUSH:     if (!fs_empty) state_nxt = S_SLOT;
            CMD_REMOVE:   if (idx_ok && idx_tail) state_nxt = S_SHIFT;
            CMD_READ:     if (idx_ok) state_nxt = S_RDATA;
            CMD_READ_TOP: if (!len_zero) state_nxt = S_RDATA;
            default:      state_nxt = S_IDLE;
          endcase
        end
      end
      S_RDATA, S_SLOT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      S_SHIFT: begin
        if (!sh_more && out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    len_nxt   = len_r;
    fc_nxt    = fc_r;
    sh_rd_nxt = sh_rd_r;
    wa_nxt    = wa_r;
    pend_nxt  = 1'b0;
    emit      = 1'b0;
    res_idx   = '0;
    res_val   = '0;
    res_sts   = STS_OK;
    elem_we   = 1'b0;
    elem_wa   = AW'(len_r);
    elem_wd   = ELEMENT_WIDTH'(wval_r);
    elem_re   = 1'b0;
    elem_ra   = AW'(idx_r);
    fs_we     = 1'b0;
    fs_wa     = FW'(fc_r);
    fs_wd     = idx_r;
    fs_re     = 1'b0;
    fs_ra     = FW'(fc_r - FCW'(1));
    case (state_r)
      S_EXEC: begin
        if (out_free) begin
          case (cmd_t'(cmd_r))
            CMD_PUSH: begin
              if (!fs_empty) begin
                fs_re  = 1'b1;
                fc_nxt = fc_r - FCW'(1);
              end else if (tbl_full) begin
                emit    = 1'b1;
                res_sts = STS_FULL;
              end else begin
                elem_we = 1'b1;
                res_idx = SLOT_W'(len_r);
                len_nxt = len_r + LW'(1);
                emit    = 1'b1;
              end
            end
            CMD_FREE: begin
              emit = 1'b1;
              if (!idx_ok) begin
                res_sts = STS_RANGE;
              end else if (fs_full) begin
                res_sts = STS_FREE_FULL;
              end else begin
                fs_we  = 1'b1;
                fc_nxt = fc_r + FCW'(1);
              end
            end
            CMD_REMOVE: begin
              if (!idx_ok) begin
                emit    = 1'b1;
                res_sts = STS_RANGE;
              end else if (idx_tail) begin
                sh_rd_nxt = LW'(CW'(idx_r) + CW'(1));
              end else begin
                emit    = 1'b1;
                len_nxt = len_r - LW'(1);
              end
            end
            CMD_POP: begin
              emit = 1'b1;
              if (len_zero) res_sts = STS_RANGE;
              else len_nxt = len_r - LW'(1);
            end
            CMD_READ: begin
              if (!idx_ok) begin
                emit    = 1'b1;
                res_sts = STS_RANGE;
              end else begin
                elem_re = 1'b1;
              end
            end
            CMD_READ_TOP: begin
              if (len_zero) begin
                emit    = 1'b1;
                res_sts = STS_RANGE;
              end else begin
                elem_re = 1'b1;
                elem_ra = AW'(len_r - LW'(1));
              end
            end
            default: emit = 1'b1;
          endcase
        end
      end
      S_RDATA: begin
        if (out_free) begin
          emit    = 1'b1;
          res_val = VALUE_W'(elem_rd_r);
        end
      end
      S_SLOT: begin
        if (out_free) begin
          emit    = 1'b1;
          res_idx = fs_rd_r;
          elem_we = slot_ok;
          elem_wa = AW'(fs_rd_r);
        end
      end
      S_SHIFT: begin
        if (pend_r) begin
          elem_we = 1'b1;
          elem_wa = wa_r;
          elem_wd = elem_rd_r;
        end
        if (sh_more) begin
          elem_re   = 1'b1;
          elem_ra   = AW'(sh_rd_r);
          wa_nxt    = AW'(sh_rd_r - LW'(1));
          sh_rd_nxt = sh_rd_r + LW'(1);
          pend_nxt  = 1'b1;
        end else if (out_free) begin
          emit    = 1'b1;
          len_nxt = len_r - LW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (emit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      fc_r        <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      fc_r        <= fc_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_rd_r <= sh_rd_nxt;
    wa_r    <= wa_nxt;
    if (in_fire) begin
      cmd_r  <= in_cmd;
      idx_r  <= in_slot_index;
      wval_r <= in_write_value;
    end
    if (emit) begin
      out_idx_r <= res_idx;
      out_val_r <= res_val;
      out_sts_r <= res_sts;
      out_cnt_r <= COUNT_W'(len_nxt);
    end
  end

  `STFS_ASSERT_IMP(a_len_bound, clk, rst_n, 1'b1, len_r <= LW'(TABLE_DEPTH), "length beyond table depth")
  `STFS_ASSERT_IMP(a_fc_bound, clk, rst_n, 1'b1, fc_r <= FCW'(FREE_DEPTH), "free count beyond stack depth")
  `STFS_ASSERT_NXT(a_accept_exec, clk, rst_n, in_fire, state_r == S_EXEC, "accepted command not executed")
  `STFS_ASSERT_IMP(a_shift_order, clk, rst_n, (state_r == S_SHIFT) && pend_r, LW'(wa_r) < len_r, "shift write outside table")

endmodule
